// ===== sv/gff_pkg.sv =====
// Package for the grid flood fill block: codes, command and status words.
`timescale 1ns / 1ps
`default_nettype none

package gff_pkg;

    localparam int CFG_W   = 7;
    localparam int CFG_IW  = 1;
    localparam int SYM_W   = 8;
    localparam int COORD_W = 6;

    localparam logic [CFG_IW-1:0] CFG_ROWS = 1'b0;
    localparam logic [CFG_IW-1:0] CFG_COLS = 1'b1;

    localparam logic [CFG_W-1:0] ROWS_RESET = 7'd64;
    localparam logic [CFG_W-1:0] COLS_RESET = 7'd64;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_READ  = 2'd1,
        ACT_FILL  = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        RES_ZERO = 2'd0,
        RES_OOR  = 2'd1,
        RES_SYM  = 2'd2,
        RES_OLD  = 2'd3
    } res_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE     = 3'd0,
        ST_CHECK    = 3'd1,
        ST_SEED     = 3'd2,
        ST_POP      = 3'd3,
        ST_POP_WAIT = 3'd4,
        ST_NB_ISSUE = 3'd5,
        ST_NB_CHECK = 3'd6,
        ST_DONE     = 3'd7
    } state_t;

    typedef struct packed {
        logic     load_item;
        logic     use_nb;
        logic     grid_rd;
        logic     grid_wr;
        logic     push;
        logic     pop;
        logic     latch_old;
        logic     latch_cur;
        logic     nb_inc;
        logic     res_load;
        res_sel_t res_sel;
    } cmd_t;

    typedef struct packed {
        action_t action;
        logic    seed_oor;
        logic    depth_zero;
        logic    nb_valid;
        logic    nb_last;
        logic    match;
        logic    same_sym;
    } status_t;

endpackage

`default_nettype wire

// ===== sv/gff_datapath.sv =====
// Datapath for the grid flood fill: config, grid and stack memories, neighbour logic.
`timescale 1ns / 1ps
`default_nettype none

module gff_datapath #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [gff_pkg::CFG_IW-1:0] cfg_index,
    input  wire logic [gff_pkg::CFG_W-1:0]  cfg_data,
    input  wire logic [1:0]                 action,
    input  wire logic [gff_pkg::COORD_W-1:0] row,
    input  wire logic [gff_pkg::COORD_W-1:0] col,
    input  wire logic [gff_pkg::SYM_W-1:0]  symbol,
    input  wire gff_pkg::cmd_t              cmd,
    output gff_pkg::status_t                status,
    output logic [gff_pkg::SYM_W-1:0]       cell_value,
    output logic                            out_of_range
);

    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int RAW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CAW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int DW    = $clog2(CELLS + 1);
    localparam int RNW   = $clog2(MAX_ROWS + 2);
    localparam int CNW   = $clog2(MAX_COLS + 2);
    localparam int NW0   = (RNW > CNW) ? RNW : CNW;
    localparam int NW    = (NW0 > gff_pkg::CFG_W + 1) ? NW0 : gff_pkg::CFG_W + 1;
    localparam int SW    = RAW + CAW;

    localparam logic [NW-1:0] MAX_R_N = NW'(MAX_ROWS);
    localparam logic [NW-1:0] MAX_C_N = NW'(MAX_COLS);

    logic [gff_pkg::CFG_W-1:0]   rows_reg;
    logic [gff_pkg::CFG_W-1:0]   cols_reg;
    logic [1:0]                  action_reg;
    logic [gff_pkg::COORD_W-1:0] row_reg;
    logic [gff_pkg::COORD_W-1:0] col_reg;
    logic [gff_pkg::SYM_W-1:0]   sym_reg;
    logic [gff_pkg::SYM_W-1:0]   old_reg;
    logic [gff_pkg::SYM_W-1:0]   grid_rd_reg;
    logic [SW-1:0]               stack_rd_reg;
    logic [RAW-1:0]              cur_r_reg;
    logic [CAW-1:0]              cur_c_reg;
    logic [1:0]                  nb_reg;
    logic [DW-1:0]               depth_reg;
    logic [DW-1:0]               depth_next;
    logic [gff_pkg::SYM_W-1:0]   value_reg;
    logic                        oor_reg;

    logic [gff_pkg::SYM_W-1:0] grid_mem  [CELLS];
    logic [SW-1:0]             stack_mem [CELLS];

    logic [NW-1:0]  eff_r;
    logic [NW-1:0]  eff_c;
    logic [NW-1:0]  seed_r_n;
    logic [NW-1:0]  seed_c_n;
    logic [NW-1:0]  cur_r_n;
    logic [NW-1:0]  cur_c_n;
    logic [NW-1:0]  nb_r_n;
    logic [NW-1:0]  nb_c_n;
    logic           edge_ok;
    logic [RAW-1:0] sel_r;
    logic [CAW-1:0] sel_c;
    logic [AW-1:0]  grid_addr;
    logic [DW-1:0]  depth_m1;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= gff_pkg::ROWS_RESET;
            cols_reg <= gff_pkg::COLS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                gff_pkg::CFG_ROWS: rows_reg <= cfg_data;
                gff_pkg::CFG_COLS: cols_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        eff_r    = (NW'(rows_reg) > MAX_R_N) ? MAX_R_N : NW'(rows_reg);
        eff_c    = (NW'(cols_reg) > MAX_C_N) ? MAX_C_N : NW'(cols_reg);
        seed_r_n = NW'(row_reg);
        seed_c_n = NW'(col_reg);
        cur_r_n  = NW'(cur_r_reg);
        cur_c_n  = NW'(cur_c_reg);
        nb_r_n   = cur_r_n;
        nb_c_n   = cur_c_n;
        edge_ok  = 1'b1;
        case (nb_reg)
            2'd0:
            begin
                nb_c_n  = cur_c_n - 1'b1;
                edge_ok = (cur_c_reg != '0);
            end
            2'd1: nb_c_n = cur_c_n + 1'b1;
            2'd2:
            begin
                nb_r_n  = cur_r_n - 1'b1;
                edge_ok = (cur_r_reg != '0);
            end
            default: nb_r_n = cur_r_n + 1'b1;
        endcase
        sel_r     = cmd.use_nb ? nb_r_n[RAW-1:0] : seed_r_n[RAW-1:0];
        sel_c     = cmd.use_nb ? nb_c_n[CAW-1:0] : seed_c_n[CAW-1:0];
        grid_addr = AW'(AW'(sel_r) * AW'(MAX_COLS) + AW'(sel_c));
        depth_m1  = depth_reg - 1'b1;
    end

    assign status.action     = gff_pkg::action_t'(action_reg);
    assign status.seed_oor   = !((seed_r_n < eff_r) && (seed_c_n < eff_c));
    assign status.depth_zero = (depth_reg == '0);
    assign status.nb_valid   = edge_ok && (nb_r_n < eff_r) && (nb_c_n < eff_c);
    assign status.nb_last    = (nb_reg == 2'd3);
    assign status.match      = (grid_rd_reg == old_reg);
    assign status.same_sym   = (grid_rd_reg == sym_reg);

    // item word and working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            action_reg <= action;
            row_reg    <= row;
            col_reg    <= col;
            sym_reg    <= symbol;
        end
        if (cmd.latch_old)
            old_reg <= grid_rd_reg;
        if (cmd.latch_cur)
        begin
            cur_r_reg <= stack_rd_reg[SW-1:CAW];
            cur_c_reg <= stack_rd_reg[CAW-1:0];
        end
        if (cmd.res_load)
        begin
            case (cmd.res_sel)
                gff_pkg::RES_OOR:
                begin
                    value_reg <= '0;
                    oor_reg   <= 1'b1;
                end
                gff_pkg::RES_SYM:
                begin
                    value_reg <= sym_reg;
                    oor_reg   <= 1'b0;
                end
                gff_pkg::RES_OLD:
                begin
                    value_reg <= grid_rd_reg;
                    oor_reg   <= 1'b0;
                end
                default:
                begin
                    value_reg <= '0;
                    oor_reg   <= 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            nb_reg <= '0;
        else if (cmd.latch_cur)
            nb_reg <= '0;
        else if (cmd.nb_inc)
            nb_reg <= nb_reg + 1'b1;
    end

    always_comb
    begin
        depth_next = depth_reg;
        if (cmd.push)
            depth_next = depth_reg + 1'b1;
        else if (cmd.pop)
            depth_next = depth_m1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            depth_reg <= '0;
        else
            depth_reg <= depth_next;
    end

    // grid memory
    always_ff @(posedge clk)
    begin
        if (cmd.grid_wr)
            grid_mem[grid_addr] <= sym_reg;
        if (cmd.grid_rd)
            grid_rd_reg <= grid_mem[grid_addr];
    end

    // coordinate stack
    always_ff @(posedge clk)
    begin
        if (cmd.push)
            stack_mem[depth_reg[AW-1:0]] <= {sel_r, sel_c};
        if (cmd.pop)
            stack_rd_reg <= stack_mem[depth_m1[AW-1:0]];
    end

    assign cell_value   = value_reg;
    assign out_of_range = oor_reg;

endmodule

`default_nettype wire

// ===== sv/gff_ctrl.sv =====
// Controller state machine for the grid flood fill.
`timescale 1ns / 1ps
`default_nettype none

module gff_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire gff_pkg::status_t status,
    output gff_pkg::cmd_t         cmd,
    output logic                  busy,
    output logic                  done
);

    gff_pkg::state_t state_reg;
    gff_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= gff_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.res_sel = gff_pkg::RES_ZERO;
        busy        = (state_reg != gff_pkg::ST_IDLE);
        done        = 1'b0;
        unique case (state_reg)
            gff_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = gff_pkg::ST_CHECK;
                end
            end
            gff_pkg::ST_CHECK:
            begin
                unique case (status.action) inside
                    gff_pkg::ACT_WRITE, gff_pkg::ACT_READ, gff_pkg::ACT_FILL:
                    begin
                        if (status.seed_oor)
                        begin
                            cmd.res_load = 1'b1;
                            cmd.res_sel  = gff_pkg::RES_OOR;
                            state_next   = gff_pkg::ST_DONE;
                        end
                        else
                        begin
                            cmd.grid_rd = 1'b1;
                            state_next  = gff_pkg::ST_SEED;
                        end
                    end
                    default:
                    begin
                        cmd.res_load = 1'b1;
                        state_next   = gff_pkg::ST_DONE;
                    end
                endcase
            end
            gff_pkg::ST_SEED:
            begin
                cmd.latch_old = 1'b1;
                cmd.res_load  = 1'b1;
                state_next    = gff_pkg::ST_DONE;
                unique case (status.action)
                    gff_pkg::ACT_WRITE:
                    begin
                        cmd.grid_wr = 1'b1;
                        cmd.res_sel = gff_pkg::RES_SYM;
                    end
                    gff_pkg::ACT_READ: cmd.res_sel = gff_pkg::RES_OLD;
                    gff_pkg::ACT_FILL:
                    begin
                        cmd.res_sel = gff_pkg::RES_OLD;
                        if (!status.same_sym)
                        begin
                            cmd.grid_wr = 1'b1;
                            cmd.push    = 1'b1;
                            state_next  = gff_pkg::ST_POP;
                        end
                    end
                    default: ;
                endcase
            end
            gff_pkg::ST_POP:
            begin
                if (status.depth_zero)
                    state_next = gff_pkg::ST_DONE;
                else
                begin
                    cmd.pop    = 1'b1;
                    state_next = gff_pkg::ST_POP_WAIT;
                end
            end
            gff_pkg::ST_POP_WAIT:
            begin
                cmd.latch_cur = 1'b1;
                state_next    = gff_pkg::ST_NB_ISSUE;
            end
            gff_pkg::ST_NB_ISSUE:
            begin
                cmd.use_nb = 1'b1;
                if (status.nb_valid)
                begin
                    cmd.grid_rd = 1'b1;
                    state_next  = gff_pkg::ST_NB_CHECK;
                end
                else
                begin
                    cmd.nb_inc = 1'b1;
                    state_next = status.nb_last ? gff_pkg::ST_POP : gff_pkg::ST_NB_ISSUE;
                end
            end
            gff_pkg::ST_NB_CHECK:
            begin
                cmd.use_nb = 1'b1;
                cmd.nb_inc = 1'b1;
                if (status.match)
                begin
                    cmd.grid_wr = 1'b1;
                    cmd.push    = 1'b1;
                end
                state_next = status.nb_last ? gff_pkg::ST_POP : gff_pkg::ST_NB_ISSUE;
            end
            gff_pkg::ST_DONE:
            begin
                done       = 1'b1;
                state_next = gff_pkg::ST_IDLE;
            end
            default: state_next = gff_pkg::ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/grid_flood_fill.sv =====
// Top level of the grid flood fill block.
//
//  channel  | handshake        | words
//  ---------+------------------+-----------------------------------
//  item in  | start, busy      | action, row, col, symbol
//  result   | done (1 cycle)   | cell_value, out_of_range
//  config   | cfg_we           | cfg_index, cfg_data
//
// Write, read or same-colour fill: states CHECK, SEED, DONE; unused action or
// bad address: states CHECK, DONE.
// Fill: neighbours of each popped cell are read and checked in turn, limited by
// the single port of the grid memory, one neighbour read at a time.
// Grid and stack need no clearing after reset; the block is ready at once.
// busy is set by the state register after accept and stays high through the done cycle; done cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none

module grid_flood_fill #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [gff_pkg::CFG_IW-1:0]  cfg_index,
    input  wire logic [gff_pkg::CFG_W-1:0]   cfg_data,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [1:0]                  action,
    input  wire logic [gff_pkg::COORD_W-1:0] row,
    input  wire logic [gff_pkg::COORD_W-1:0] col,
    input  wire logic [gff_pkg::SYM_W-1:0]   symbol,
    output logic                             done,
    output logic [gff_pkg::SYM_W-1:0]        cell_value,
    output logic                             out_of_range
);

    gff_pkg::cmd_t    cmd;
    gff_pkg::status_t status;

    gff_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    gff_datapath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .action       (action),
        .row          (row),
        .col          (col),
        .symbol       (symbol),
        .cmd          (cmd),
        .status       (status),
        .cell_value   (cell_value),
        .out_of_range (out_of_range)
    );

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result word outside a busy item");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done && !busy)
        else $error("result strobe longer than one cycle");

    a_oor_value: assert property (@(posedge clk) disable iff (!rst_n)
        (done && out_of_range) |-> (cell_value == '0))
        else $error("out of range result carries a value");

endmodule

`default_nettype wire

// ===== tb/tb_grid_flood_fill.sv =====
// Self-checking bench for grid_flood_fill: corner writes, directed table, random phases.
`timescale 1ns / 1ps

module tb_grid_flood_fill;

    localparam int GRID_DIM = 64;
    localparam int BLOCK    = 8;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef logic [gff_pkg::COORD_W-1:0] coord_t;
    typedef logic [gff_pkg::SYM_W-1:0]   sym_t;
    typedef logic [gff_pkg::CFG_W-1:0]   cfg_t;
    typedef logic [gff_pkg::CFG_IW-1:0]  cfg_idx_t;

    typedef enum logic {
        ROW_CMD,
        ROW_REG
    } row_kind_t;

    typedef struct packed {
        sym_t value;
        logic oor;
    } cell_result_t;

    typedef struct packed {
        row_kind_t  kind;
        logic [1:0] act;
        coord_t     r;
        coord_t     c;
        sym_t       sym;
        logic       typed;
        sym_t       want_value;
        logic       want_oor;
        cfg_idx_t   reg_idx;
        cfg_t       reg_data;
    } dir_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    cfg_idx_t             cfg_index;
    cfg_t                 cfg_data;
    logic                 start;
    logic                 busy;
    logic [1:0]           action;
    coord_t               row;
    coord_t               col;
    sym_t                 symbol;
    logic                 done;
    sym_t                 cell_value;
    logic                 out_of_range;

    sym_t                 shadow_grid [0:GRID_DIM*GRID_DIM-1];
    int                   fill_stack [$];
    cfg_t                 rows_cfg;
    cfg_t                 cols_cfg;
    cell_result_t         expected_cells [$];
    dir_row_t             directed [$];
    int                   mismatches;
    logic                 no_idle;

    grid_flood_fill dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .row          (row),
        .col          (col),
        .symbol       (symbol),
        .done         (done),
        .cell_value   (cell_value),
        .out_of_range (out_of_range)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int eff_dim(input cfg_t v);
        return (v > GRID_DIM) ? GRID_DIM : int'(v);
    endfunction

    function automatic int gap_cycles();
        int p;
        p = $urandom_range(0, 99);
        if (no_idle || p < 55)
            return 0;
        if (p < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    function automatic dir_row_t dir_cmd(input logic [1:0] act, input int r, input int c,
                                         input int s, input logic typed, input int wv,
                                         input logic wo);
        dir_row_t d;
        d = '0;
        d.kind = ROW_CMD;
        d.act = act;
        d.r = coord_t'(r);
        d.c = coord_t'(c);
        d.sym = sym_t'(s);
        d.typed = typed;
        d.want_value = sym_t'(wv);
        d.want_oor = wo;
        return d;
    endfunction

    function automatic dir_row_t dir_reg(input cfg_idx_t idx, input int data);
        dir_row_t d;
        d = '0;
        d.kind = ROW_REG;
        d.reg_idx = idx;
        d.reg_data = cfg_t'(data);
        return d;
    endfunction

    // paint on push, so a cell enters the stack once
    task automatic paint_cell(input int r, input int c, input sym_t old_s, input sym_t new_s);
        int idx;
        if (r >= eff_dim(rows_cfg) || c >= eff_dim(cols_cfg))
            return;
        idx = r * GRID_DIM + c;
        if (shadow_grid[idx] != old_s)
            return;
        shadow_grid[idx] = new_s;
        fill_stack.push_back(idx);
    endtask

    task automatic flood_region(input int r0, input int c0, input sym_t old_s,
                                input sym_t new_s);
        int idx;
        int r;
        int c;
        fill_stack.delete();
        paint_cell(r0, c0, old_s, new_s);
        while (fill_stack.size() > 0)
        begin
            idx = fill_stack.pop_back();
            r = idx / GRID_DIM;
            c = idx % GRID_DIM;
            if (c > 0)
                paint_cell(r, c - 1, old_s, new_s);
            paint_cell(r, c + 1, old_s, new_s);
            if (r > 0)
                paint_cell(r - 1, c, old_s, new_s);
            paint_cell(r + 1, c, old_s, new_s);
        end
    endtask

    task automatic predict_grid_item(input logic [1:0] act, input coord_t r, input coord_t c,
                                     input sym_t s, output sym_t val, output logic oor);
        int idx;
        sym_t old_s;
        val = '0;
        oor = 1'b0;
        idx = int'(r) * GRID_DIM + int'(c);
        if (act == ACT_UNUSED)
            return;
        if (int'(r) >= eff_dim(rows_cfg) || int'(c) >= eff_dim(cols_cfg))
        begin
            oor = 1'b1;
            return;
        end
        old_s = shadow_grid[idx];
        case (act)
            gff_pkg::ACT_WRITE:
            begin
                shadow_grid[idx] = s;
                val = s;
            end
            gff_pkg::ACT_READ:
                val = old_s;
            default:
            begin
                val = old_s;
                if (s != old_s)
                    flood_region(int'(r), int'(c), old_s, s);
            end
        endcase
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (expected_cells.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input cfg_t data);
        wait_drained();
        repeat (2) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == gff_pkg::CFG_ROWS)
            rows_cfg = data;
        else
            cols_cfg = data;
    endtask

    // start is left high on return so a back-to-back word is taken without start falling in between
    task automatic issue_cmd(input logic [1:0] act, input coord_t r, input coord_t c,
                             input sym_t s, input logic typed, input sym_t tval,
                             input logic toor);
        int gap;
        sym_t pval;
        logic poor;
        cell_result_t res;
        gap = gap_cycles();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        action <= act;
        row <= r;
        col <= c;
        symbol <= s;
        do
            @(posedge clk);
        while (busy);
        predict_grid_item(act, r, c, s, pval, poor);
        res.value = typed ? tval : pval;
        res.oor = typed ? toor : poor;
        expected_cells.push_back(res);
    endtask

    always @(posedge clk)
    begin
        cell_result_t want;
        if (rst_n && done)
        begin
            if (expected_cells.size() == 0)
            begin
                $error("unexpected result: cell_value %0d out_of_range %0d",
                       cell_value, out_of_range);
                mismatches = mismatches + 1;
            end
            else
            begin
                want = expected_cells.pop_front();
                if (cell_value !== want.value)
                begin
                    $error("cell_value: expected %0d, actual %0d", want.value, cell_value);
                    mismatches = mismatches + 1;
                end
                if (out_of_range !== want.oor)
                begin
                    $error("out_of_range: expected %0d, actual %0d", want.oor, out_of_range);
                    mismatches = mismatches + 1;
                end
            end
        end
    end

    initial
    begin
        #100000000;
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        int i;
        int phase;
        int n;
        int effr;
        int effc;
        int p;
        logic [1:0] act;
        coord_t r;
        coord_t c;
        sym_t s;
        dir_row_t d;

        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        start = 1'b0;
        action = '0;
        row = '0;
        col = '0;
        symbol = '0;
        mismatches = 0;
        no_idle = 1'b0;
        rows_cfg = gff_pkg::ROWS_RESET;
        cols_cfg = gff_pkg::COLS_RESET;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // the corner block is written first; fills and reads stay inside written cells
        for (i = 0; i < BLOCK * BLOCK; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                s = sym_t'($urandom_range(0, 255));
            else
                s = sym_t'($urandom_range(0, 3));
            issue_cmd(gff_pkg::ACT_WRITE, coord_t'(i / BLOCK), coord_t'(i % BLOCK), s,
                      1'b0, '0, 1'b0);
        end

        directed.push_back(dir_cmd(gff_pkg::ACT_WRITE,  0,  0,   0, 1'b1,   0, 1'b0));
        directed.push_back(dir_cmd(gff_pkg::ACT_WRITE, 63, 63, 255, 1'b1, 255, 1'b0));
        directed.push_back(dir_cmd(gff_pkg::ACT_READ,  63, 63,   0, 1'b1, 255, 1'b0));
        directed.push_back(dir_cmd(gff_pkg::ACT_READ,   0,  0, 255, 1'b1,   0, 1'b0));
        directed.push_back(dir_cmd(ACT_UNUSED,         63, 63, 255, 1'b1,   0, 1'b0));
        directed.push_back(dir_cmd(gff_pkg::ACT_FILL,   0,  0,   0, 1'b1,   0, 1'b0));
        directed.push_back(dir_cmd(gff_pkg::ACT_FILL,  63, 63, 255, 1'b1, 255, 1'b0));
        directed.push_back(dir_reg(gff_pkg::CFG_ROWS, BLOCK));
        directed.push_back(dir_reg(gff_pkg::CFG_COLS, BLOCK));
        directed.push_back(dir_cmd(gff_pkg::ACT_FILL,   0,  0,   1, 1'b1,   0, 1'b0));
        directed.push_back(dir_cmd(gff_pkg::ACT_READ,   0,  0,   0, 1'b1,   1, 1'b0));
        directed.push_back(dir_reg(gff_pkg::CFG_ROWS, 2));
        directed.push_back(dir_reg(gff_pkg::CFG_COLS, 3));
        directed.push_back(dir_cmd(gff_pkg::ACT_READ,   2,  0,   0, 1'b1,   0, 1'b1));
        directed.push_back(dir_cmd(gff_pkg::ACT_READ,   0,  3,   0, 1'b1,   0, 1'b1));
        directed.push_back(dir_cmd(gff_pkg::ACT_FILL,   1,  2,   7, 1'b0,   0, 1'b0));
        directed.push_back(dir_cmd(gff_pkg::ACT_WRITE, 63, 63,   0, 1'b1,   0, 1'b1));
        directed.push_back(dir_cmd(ACT_UNUSED,          5,  5,   9, 1'b1,   0, 1'b0));
        directed.push_back(dir_reg(gff_pkg::CFG_ROWS, 0));
        directed.push_back(dir_cmd(gff_pkg::ACT_FILL,   0,  0,   3, 1'b1,   0, 1'b1));
        directed.push_back(dir_reg(gff_pkg::CFG_ROWS, 127));
        directed.push_back(dir_reg(gff_pkg::CFG_COLS, 127));
        directed.push_back(dir_cmd(gff_pkg::ACT_WRITE, 63, 62,   9, 1'b1,   9, 1'b0));
        directed.push_back(dir_cmd(gff_pkg::ACT_WRITE, 62, 63,   9, 1'b1,   9, 1'b0));
        directed.push_back(dir_cmd(gff_pkg::ACT_FILL,  63, 63,   0, 1'b1, 255, 1'b0));
        directed.push_back(dir_cmd(gff_pkg::ACT_READ,  63, 63,   0, 1'b1,   0, 1'b0));
        directed.push_back(dir_reg(gff_pkg::CFG_ROWS, 1));
        directed.push_back(dir_reg(gff_pkg::CFG_COLS, 1));
        directed.push_back(dir_cmd(gff_pkg::ACT_FILL,   0,  0, 8'h55, 1'b0, 0, 1'b0));
        directed.push_back(dir_cmd(gff_pkg::ACT_READ,   0,  1,   0, 1'b1,   0, 1'b1));

        foreach (directed[k])
        begin
            d = directed[k];
            if (d.kind == ROW_REG)
                write_reg(d.reg_idx, d.reg_data);
            else
                issue_cmd(d.act, d.r, d.c, d.sym, d.typed, d.want_value, d.want_oor);
        end

        // random grids stay inside the written corner block
        for (phase = 0; phase < 12; phase++)
        begin
            case (phase)
                3:       begin effr = BLOCK; effc = BLOCK; end
                7:       begin effr = BLOCK; effc = 1; end
                9:       begin effr = 0;     effc = $urandom_range(1, BLOCK); end
                10:      begin effr = $urandom_range(1, BLOCK); effc = 0; end
                11:      begin effr = 1;     effc = BLOCK; end
                default: begin effr = $urandom_range(1, BLOCK);
                               effc = $urandom_range(1, BLOCK); end
            endcase
            write_reg(gff_pkg::CFG_ROWS, cfg_t'(effr));
            write_reg(gff_pkg::CFG_COLS, cfg_t'(effc));
            no_idle = ($urandom_range(0, 3) == 0);
            effr = eff_dim(rows_cfg);
            effc = eff_dim(cols_cfg);
            for (n = 0; n < 5; n++)
            begin
                p = $urandom_range(0, 99);
                if (p < 30)
                    act = gff_pkg::ACT_WRITE;
                else if (p < 60)
                    act = gff_pkg::ACT_READ;
                else if (p < 94)
                    act = gff_pkg::ACT_FILL;
                else
                    act = ACT_UNUSED;
                if (effr > 0 && $urandom_range(0, 99) < 85)
                    r = coord_t'($urandom_range(0, effr - 1));
                else
                    r = coord_t'($urandom_range(0, 63));
                if (effc > 0 && $urandom_range(0, 99) < 85)
                    c = coord_t'($urandom_range(0, effc - 1));
                else
                    c = coord_t'($urandom_range(0, 63));
                if ($urandom_range(0, 99) < 85)
                    s = sym_t'($urandom_range(0, 3));
                else
                    s = sym_t'($urandom_range(0, 255));
                issue_cmd(act, r, c, s, 1'b0, '0, 1'b0);
                // at random, hold off until the block has handed back every word
                if ($urandom_range(0, 15) == 0)
                    wait_drained();
            end
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
